FILE: hw/rtl/deque_ring_with_dedup_core_defines.svh
// assertion macros for the deque ring core
`ifndef DEQUE_RING_WITH_DEDUP_CORE_DEFINES_SVH
`define DEQUE_RING_WITH_DEDUP_CORE_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define DQRD_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("dqrd: invariant violated");

// antecedent in one cycle implies consequent in the next
`define DQRD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dqrd: cycle sequence violated");

`endif

FILE: hw/rtl/dqrd_pkg.sv
// shared types and constants for the deque ring core
package dqrd_pkg;

	localparam int REQ_W = 4;
	localparam int ITEM_W = 32;
	localparam int OFFSET_W = 10;
	localparam int TICK_W = 32;
	localparam int LEN_W = 11;
	localparam int QSIZE_W = 11;
	localparam int WINDOW_W = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [QSIZE_W-1:0] QSIZE_RESET = 11'd16;
	localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd20;

	// request codes
	localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd0;
	localparam logic [REQ_W-1:0] REQ_PUSH_BACK = 4'd1;
	localparam logic [REQ_W-1:0] REQ_PEEK_AT = 4'd2;
	localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 4'd3;
	localparam logic [REQ_W-1:0] REQ_PEEK_BACK = 4'd4;
	localparam logic [REQ_W-1:0] REQ_POP_FRONT = 4'd5;
	localparam logic [REQ_W-1:0] REQ_POP_BACK = 4'd6;
	localparam logic [REQ_W-1:0] REQ_DISCARD_FRONT = 4'd7;
	localparam logic [REQ_W-1:0] REQ_DISCARD_BACK = 4'd8;
	localparam logic [REQ_W-1:0] REQ_EMPTY = 4'd9;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_QUEUE_SIZE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_DYNAMIC_MODE = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DUP_WINDOW = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0]    req_type;
		logic [ITEM_W-1:0]   item_data;
		logic [OFFSET_W-1:0] peek_offset;
		logic [TICK_W-1:0]   now_tick;
	} dqrd_req_t;

	typedef struct packed {
		logic [ITEM_W-1:0] out_data;
		logic              out_valid;
		logic              push_stored;
		logic [LEN_W-1:0]  length;
		logic [LEN_W-1:0]  capacity_now;
	} dqrd_rsp_t;

endpackage

FILE: hw/rtl/deque_ring_with_dedup_core.sv
// double-ended ring queue core with repeated-push suppression
//
//  channel | handshake               | payload
//  --------+-------------------------+-----------------------------
//  request | start / busy            | req  (dqrd_req_t)
//  result  | done strobe, one cycle  | rsp  (dqrd_rsp_t)
//  config  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// an item passes through the entry memory read issued at accept, then the update
// and write-back; a new item is not taken until that write-back is done.
// done rises in the cycle after the update, and start is taken again in that cycle.
// cfg_ready is low while an item is in flight or start is high.
// reset is asynchronous; the entry memory needs no clearing pass, so the core is
// ready right after reset. done is never held off by the receiver.
`include "deque_ring_with_dedup_core_defines.svh"

module deque_ring_with_dedup_core #(
	parameter int MAX_DEPTH = 1024,
	parameter int DATA_WIDTH = 32,
	parameter int MIN_DYNAMIC = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  dqrd_pkg::dqrd_req_t                   req,
	output logic                                  done,
	output dqrd_pkg::dqrd_rsp_t                   rsp,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [dqrd_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [dqrd_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import dqrd_pkg::*;

	localparam int AW = $clog2(MAX_DEPTH);
	localparam int CW = $clog2(MAX_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam int MIN_CAP = (MIN_DYNAMIC < MAX_DEPTH) ? MIN_DYNAMIC : MAX_DEPTH;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_DEPTH);
	localparam logic [CW-1:0] MIN_C = CW'(MIN_CAP);
	localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_DEPTH - 1);

	typedef struct packed {
		logic [AW-1:0] head;
		logic [CW-1:0] cnt;
		logic [CW-1:0] cap;
		logic [AW-1:0] lp;
		logic          chg;
	} qstate_t;

	function automatic logic [AW-1:0] mod_add(input logic [AW-1:0] a, input logic [CW-1:0] b);
		logic [SW-1:0] s;
		s = SW'(a) + SW'(b);
		if (s >= SW'(MAX_DEPTH)) begin
			s = s - SW'(MAX_DEPTH);
		end
		return AW'(s);
	endfunction

	// distance from head to a slot, going forward around the ring
	function automatic logic [AW-1:0] rel_of(input logic [AW-1:0] slot, input logic [AW-1:0] hd);
		logic [SW-1:0] s;
		if (slot >= hd) begin
			s = SW'(slot) - SW'(hd);
		end else begin
			s = SW'(slot) + SW'(MAX_DEPTH) - SW'(hd);
		end
		return AW'(s);
	endfunction

	function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
		return (s == LAST_SLOT) ? '0 : s + AW'(1);
	endfunction

	function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
		return (s == '0) ? LAST_SLOT : s - AW'(1);
	endfunction

	function automatic logic [CW-1:0] fixed_cap(input logic [QSIZE_W-1:0] v);
		if (v == '0) begin
			return CW'(1);
		end else if (32'(v) > 32'(MAX_DEPTH)) begin
			return MAX_C;
		end
		return CW'(v);
	endfunction

	// architectural state
	qstate_t               cur_q;
	logic [TICK_W-1:0]     tick_q;
	logic [QSIZE_W-1:0]    qsize_q;
	logic                  dyn_q;
	logic [WINDOW_W-1:0]   win_q;

	// entry memory
	logic [DATA_WIDTH-1:0] mem [MAX_DEPTH];

	// request stage
	logic                  v_s1;
	logic [REQ_W-1:0]      op_s1;
	logic [DATA_WIDTH-1:0] data_s1;
	logic [TICK_W-1:0]     tick_s1;
	logic                  rdok_s1;
	logic                  dupc_s1;
	logic [DATA_WIDTH-1:0] rdata_s1;

	logic                  done_q;
	dqrd_rsp_t             rsp_q;

	logic                  acc;
	logic                  cfg_wr;
	logic [AW-1:0]         raddr;
	logic                  rd_ok;
	logic [AW-1:0]         rel_cur;
	logic                  dupc;

	qstate_t               pre;
	qstate_t               mid;
	qstate_t               nxt;
	logic                  run_chk;
	logic                  rs_clr;
	logic                  is_push;
	logic                  dup;
	logic                  rd_out;
	logic                  do_rs;
	logic [CW-1:0]         newcap;
	logic [CW-1:0]         n_keep;
	logic [AW-1:0]         rel_p;
	logic [SW-1:0]         dbl;
	logic                  full;
	logic [AW-1:0]         slot;

	logic                  restart;
	logic [QSIZE_W-1:0]    qs_new;
	logic                  dyn_new;
	logic [WINDOW_W-1:0]   win_new;
	logic [CW-1:0]         cap_rst;

	assign busy = v_s1;
	assign acc = start & ~busy;
	// a write never lands on the edge that takes an item
	assign cfg_ready = ~v_s1 & ~start;
	assign cfg_wr = cfg_valid & cfg_ready;
	assign done = done_q;
	assign rsp = rsp_q;

	// read address and duplicate candidate, from state at accept
	always_comb begin
		raddr = cur_q.head;
		rd_ok = 1'b0;
		case (req.req_type) inside
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				raddr = cur_q.lp;
			end
			REQ_PEEK_AT: begin
				raddr = mod_add(cur_q.head, CW'(req.peek_offset));
				rd_ok = (cur_q.cnt != '0) && (32'(req.peek_offset) < 32'(cur_q.cnt));
			end
			REQ_PEEK_FRONT, REQ_POP_FRONT, REQ_DISCARD_FRONT: begin
				rd_ok = (cur_q.cnt != '0);
			end
			REQ_PEEK_BACK, REQ_POP_BACK, REQ_DISCARD_BACK: begin
				raddr = mod_add(cur_q.head, cur_q.cnt - CW'(1));
				rd_ok = (cur_q.cnt != '0);
			end
			default: begin
			end
		endcase
	end

	assign rel_cur = rel_of(cur_q.lp, cur_q.head);
	assign dupc = cur_q.chg && (CW'(rel_cur) < cur_q.cnt)
		&& ((req.now_tick - tick_q) < TICK_W'(win_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1 <= req.req_type;
			data_s1 <= DATA_WIDTH'(req.item_data);
			tick_s1 <= req.now_tick;
			rdok_s1 <= rd_ok;
			dupc_s1 <= dupc;
			rdata_s1 <= mem[raddr];
		end
	end

	// update stage: end operation, capacity check, then push
	always_comb begin
		pre = cur_q;
		run_chk = 1'b0;
		rs_clr = 1'b0;
		is_push = 1'b0;
		rd_out = 1'b0;
		dup = dupc_s1 && (rdata_s1 == data_s1);
		case (op_s1) inside
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (!dup) begin
					is_push = 1'b1;
					run_chk = 1'b1;
				end
			end
			REQ_PEEK_AT, REQ_PEEK_FRONT, REQ_PEEK_BACK: begin
				rd_out = rdok_s1;
			end
			REQ_POP_FRONT, REQ_DISCARD_FRONT: begin
				if (cur_q.cnt != '0) begin
					pre.head = slot_inc(cur_q.head);
					pre.cnt = cur_q.cnt - CW'(1);
					pre.chg = 1'b1;
					rd_out = (op_s1 == REQ_POP_FRONT);
				end
				run_chk = 1'b1;
			end
			REQ_POP_BACK, REQ_DISCARD_BACK: begin
				if (cur_q.cnt != '0) begin
					pre.cnt = cur_q.cnt - CW'(1);
					pre.chg = 1'b1;
					rd_out = (op_s1 == REQ_POP_BACK);
				end
				run_chk = 1'b1;
			end
			REQ_EMPTY: begin
				pre.chg = cur_q.chg | (cur_q.cnt != '0);
				pre.head = '0;
				pre.cnt = '0;
				rs_clr = dyn_q;
			end
			default: begin
			end
		endcase

		do_rs = 1'b0;
		newcap = pre.cap;
		dbl = SW'(pre.cap) << 1;
		if (rs_clr) begin
			do_rs = 1'b1;
			newcap = MIN_C;
		end else if (run_chk && dyn_q) begin
			if (pre.cnt >= pre.cap) begin
				if (pre.cap < MAX_C) begin
					do_rs = 1'b1;
					newcap = (dbl > SW'(MAX_DEPTH)) ? MAX_C : CW'(dbl);
				end
			end else if (pre.cnt < (pre.cap >> 2)) begin
				if (SW'(pre.cap) > SW'(2 * MIN_CAP)) begin
					do_rs = 1'b1;
					newcap = pre.cap >> 1;
				end else if (pre.cap > MIN_C) begin
					do_rs = 1'b1;
					newcap = MIN_C;
				end
			end
		end

		// the ring keeps its layout; a resize trims the count and pulls the last-push slot in
		n_keep = (pre.cnt < newcap) ? pre.cnt : newcap;
		rel_p = rel_of(pre.lp, pre.head);
		mid = pre;
		if (do_rs) begin
			mid.cap = newcap;
			mid.cnt = n_keep;
			mid.lp = (CW'(rel_p) < n_keep) ? pre.lp : mod_add(pre.head, n_keep);
			mid.chg = pre.chg | (n_keep != pre.cnt);
		end

		nxt = mid;
		full = (mid.cnt >= mid.cap);
		slot = mod_add(mid.head, mid.cnt);
		if (is_push) begin
			if (op_s1 == REQ_PUSH_FRONT) begin
				slot = slot_dec(mid.head);
				nxt.head = slot;
			end else if (full) begin
				// back push on a full queue drops the front item
				nxt.head = slot_inc(mid.head);
			end
			if (!full) begin
				nxt.cnt = mid.cnt + CW'(1);
			end
			nxt.lp = slot;
			nxt.chg = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && is_push) begin
			mem[slot] <= data_s1;
		end
	end

	// configuration decode
	always_comb begin
		restart = 1'b0;
		qs_new = qsize_q;
		dyn_new = dyn_q;
		win_new = win_q;
		if (cfg_wr) begin
			case (cfg_index)
				CFG_QUEUE_SIZE: begin
					qs_new = cfg_data[QSIZE_W-1:0];
					restart = 1'b1;
				end
				CFG_DYNAMIC_MODE: begin
					dyn_new = cfg_data[0];
					restart = (cfg_data[0] != dyn_q);
				end
				CFG_DUP_WINDOW: begin
					win_new = cfg_data[WINDOW_W-1:0];
				end
				default: begin
				end
			endcase
		end
		cap_rst = dyn_new ? MIN_C : fixed_cap(qs_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q.head <= '0;
			cur_q.cnt <= '0;
			cur_q.cap <= fixed_cap(QSIZE_RESET);
			cur_q.lp <= '0;
			cur_q.chg <= 1'b0;
			tick_q <= '0;
			qsize_q <= QSIZE_RESET;
			dyn_q <= 1'b0;
			win_q <= WINDOW_RESET;
		end else if (v_s1) begin
			cur_q <= nxt;
			if (is_push) begin
				tick_q <= tick_s1;
			end
		end else if (cfg_wr) begin
			qsize_q <= qs_new;
			dyn_q <= dyn_new;
			win_q <= win_new;
			if (restart) begin
				cur_q.head <= '0;
				cur_q.cnt <= '0;
				cur_q.cap <= cap_rst;
				cur_q.lp <= '0;
				cur_q.chg <= cur_q.chg | (cur_q.cnt != '0);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			rsp_q.out_data <= rd_out ? ITEM_W'(rdata_s1) : '0;
			rsp_q.out_valid <= rd_out;
			rsp_q.push_stored <= is_push;
			rsp_q.length <= LEN_W'(nxt.cnt);
			rsp_q.capacity_now <= LEN_W'(nxt.cap);
		end
	end

	`DQRD_ASSERT_ALWAYS(a_cnt_le_cap, cur_q.cnt <= cur_q.cap)
	`DQRD_ASSERT_ALWAYS(a_cap_range, (cur_q.cap != '0) && (cur_q.cap <= MAX_C))
	`DQRD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`DQRD_ASSERT_NEXT(a_busy_done, busy, done && !busy)
	`DQRD_ASSERT_ALWAYS(a_head_in_ring, (cur_q.head <= LAST_SLOT) && (cur_q.lp <= LAST_SLOT))

endmodule
